// ===== rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// shared widths, constants, types and elaboration helpers for the sine/cosine
// taylor series core
// ----------------------------------------------------------------------------
package sct_pkg;

    // default series lengths
    localparam int SINE_TERMS_DEF   = 3;
    localparam int COSINE_TERMS_DEF = 5;

    // port field widths
    localparam int ANGLE_W = 16;
    localparam int LIMIT_W = 15;
    localparam int VALUE_W = 16;

    // internal widths
    localparam int MAG_W   = 15;                     // in-range angle magnitude, q12
    localparam int TERM_W  = 37;                     // term magnitude, q28, x < 8
    localparam int FRAC_SH = 12;                     // q12 angle scaling
    localparam int PROD_W  = TERM_W + MAG_W;         // term times magnitude
    localparam int Q_W     = PROD_W - FRAC_SH;       // product back in q28
    localparam int HI_W    = 20;                     // upper dividend chunk
    localparam int LO_W    = Q_W - HI_W;             // lower dividend chunk
    localparam int DIV_W   = 4;                      // divisors up to 15
    localparam int RCP1_SH = HI_W + DIV_W;
    localparam int RCP1_W  = RCP1_SH + 1;
    localparam int NUM2_W  = DIV_W + LO_W;
    localparam int RCP2_SH = NUM2_W + DIV_W;
    localparam int RCP2_W  = RCP2_SH + 1;
    localparam int SUM_W   = 42;                     // signed q28 running sum
    localparam int INIT_SH = 16;                     // q12 angle to q28
    localparam int ONE_SH  = 28;
    localparam int ROUND_SH = 14;                    // q28 to q14
    localparam int RND_W   = SUM_W - ROUND_SH;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(12867);
    localparam logic [TERM_W-1:0]  TERM_ONE    = TERM_W'(1) << ONE_SH;
    localparam logic [SUM_W-1:0]   ROUND_HALF  = SUM_W'(1) << (ROUND_SH - 1);
    localparam logic [VALUE_W-1:0] POS_LIMIT   = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] NEG_LIMIT   = {1'b1, {(VALUE_W-1){1'b0}}};

    // what a step does with the term it receives
    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB
    } t_term_op;

    // control and running sum that travel down the pipeline
    typedef struct packed {
        logic                    valid;
        logic                    cosine;
        logic                    neg_angle;
        logic                    oor;
        logic [MAG_W-1:0]        mag;
        logic signed [SUM_W-1:0] sum;
    } t_ctl;

    typedef struct packed {
        t_ctl              ctl;
        logic [TERM_W-1:0] term;
    } t_stage;

    // two half-steps per term after the first, longest series sets the depth
    function automatic int series_steps(input int sine_terms, input int cosine_terms);
        int longest;
        longest = (sine_terms > cosine_terms) ? sine_terms : cosine_terms;
        return 2 * (longest - 1);
    endfunction

    // a term finishes every second step; terms alternate in sign
    function automatic t_term_op term_op(input int step, input int terms);
        t_term_op op;
        op = OP_NONE;
        if (step >= 2 && (step % 2) == 0 && step <= 2 * (terms - 1)) begin
            op = (((step / 2) % 2) == 1) ? OP_SUB : OP_ADD;
        end
        return op;
    endfunction

endpackage

// ===== rtl/sct_in_if.sv =====
// ----------------------------------------------------------------------------
// sct_in_if
// angle channel: function select and q3.12 angle with valid/ready
// ----------------------------------------------------------------------------
interface sct_in_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic signed [sct_pkg::ANGLE_W-1:0]  angle;

    modport source (output valid, output func, output angle, input ready);
    modport sink   (input valid, input func, input angle, output ready);
endinterface

// ===== rtl/sct_out_if.sv =====
// ----------------------------------------------------------------------------
// sct_out_if
// result channel: q2.14 value and range error flag with valid/ready
// ----------------------------------------------------------------------------
interface sct_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sct_pkg::VALUE_W-1:0]  value;
    logic                                out_of_range;

    modport source (output valid, output value, output out_of_range, input ready);
    modport sink   (input valid, input value, input out_of_range, output ready);
endinterface

// ===== rtl/sct_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sct_cfg_if
// configuration write channel for the angle limit register
// ----------------------------------------------------------------------------
interface sct_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sct_pkg::LIMIT_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sct_step.sv =====
// ----------------------------------------------------------------------------
// sct_step
// one series half-step in four stages: multiply by |x|, then exact division
// by a small constant through two reciprocal multiplies
// ----------------------------------------------------------------------------
module sct_step #(
    parameter int STEP         = 0,
    parameter int SINE_TERMS   = sct_pkg::SINE_TERMS_DEF,
    parameter int COSINE_TERMS = sct_pkg::COSINE_TERMS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  sct_pkg::t_stage i_stage,
    output sct_pkg::t_stage o_stage
);

    localparam int TERM_W  = sct_pkg::TERM_W;
    localparam int PROD_W  = sct_pkg::PROD_W;
    localparam int Q_W     = sct_pkg::Q_W;
    localparam int HI_W    = sct_pkg::HI_W;
    localparam int LO_W    = sct_pkg::LO_W;
    localparam int DIV_W   = sct_pkg::DIV_W;
    localparam int RCP1_SH = sct_pkg::RCP1_SH;
    localparam int RCP1_W  = sct_pkg::RCP1_W;
    localparam int NUM2_W  = sct_pkg::NUM2_W;
    localparam int RCP2_SH = sct_pkg::RCP2_SH;
    localparam int RCP2_W  = sct_pkg::RCP2_W;
    localparam int SUM_W   = sct_pkg::SUM_W;
    localparam int P1_W    = HI_W + RCP1_W;
    localparam int QN_W    = HI_W + DIV_W;
    localparam int P2_W    = NUM2_W + RCP2_W;

    // sine divides by 2,3,4,... and cosine by 1,2,3,...
    localparam int N_SIN = STEP + 2;
    localparam int N_COS = STEP + 1;

    localparam logic [DIV_W-1:0]  DIV_SIN  = DIV_W'(N_SIN);
    localparam logic [DIV_W-1:0]  DIV_COS  = DIV_W'(N_COS);
    localparam logic [RCP1_W-1:0] RCP1_SIN = RCP1_W'(((64'd1 << RCP1_SH) + N_SIN - 1) / N_SIN);
    localparam logic [RCP1_W-1:0] RCP1_COS = RCP1_W'(((64'd1 << RCP1_SH) + N_COS - 1) / N_COS);
    localparam logic [RCP2_W-1:0] RCP2_SIN = RCP2_W'(((64'd1 << RCP2_SH) + N_SIN - 1) / N_SIN);
    localparam logic [RCP2_W-1:0] RCP2_COS = RCP2_W'(((64'd1 << RCP2_SH) + N_COS - 1) / N_COS);

    localparam sct_pkg::t_term_op OP_SIN = sct_pkg::term_op(STEP, SINE_TERMS);
    localparam sct_pkg::t_term_op OP_COS = sct_pkg::term_op(STEP, COSINE_TERMS);

    typedef struct packed {
        sct_pkg::t_ctl    ctl;
        logic [Q_W-1:0]   q;
    } t_mul;

    typedef struct packed {
        sct_pkg::t_ctl    ctl;
        logic [HI_W-1:0]  hi;
        logic [HI_W-1:0]  qh;
        logic [LO_W-1:0]  lo;
    } t_div_hi;

    typedef struct packed {
        sct_pkg::t_ctl    ctl;
        logic [HI_W-1:0]  qh;
        logic [DIV_W-1:0] rh;
        logic [LO_W-1:0]  lo;
    } t_div_rem;

    t_mul            r_a, n_a;
    t_div_hi         r_b, n_b;
    t_div_rem        r_c, n_c;
    sct_pkg::t_stage r_d, n_d;

    logic [PROD_W-1:0]       a_prod;
    logic signed [SUM_W-1:0] a_term;
    sct_pkg::t_term_op       a_op;
    logic [RCP1_W-1:0]       b_rcp;
    logic [P1_W-1:0]         b_prod;
    logic [DIV_W-1:0]        c_div;
    logic [QN_W-1:0]         c_qn;
    logic [HI_W-1:0]         c_rem;
    logic [NUM2_W-1:0]       d_num;
    logic [RCP2_W-1:0]       d_rcp;
    logic [P2_W-1:0]         d_prod;

    // stage a: fold in a finished term, multiply by |x| and drop to q28
    always_comb begin
        n_a.ctl = i_stage.ctl;
        a_op    = i_stage.ctl.cosine ? OP_COS : OP_SIN;
        a_term  = signed'(SUM_W'(i_stage.term));
        unique case (a_op)
            sct_pkg::OP_ADD: n_a.ctl.sum = i_stage.ctl.sum + a_term;
            sct_pkg::OP_SUB: n_a.ctl.sum = i_stage.ctl.sum - a_term;
            default:         n_a.ctl.sum = i_stage.ctl.sum;
        endcase
        a_prod = PROD_W'(i_stage.term) * PROD_W'(i_stage.ctl.mag);
        n_a.q  = a_prod[sct_pkg::FRAC_SH +: Q_W];
    end

    // stage b: quotient of the upper chunk
    always_comb begin
        n_b.ctl = r_a.ctl;
        n_b.hi  = r_a.q[Q_W-1 -: HI_W];
        n_b.lo  = r_a.q[LO_W-1:0];
        b_rcp   = r_a.ctl.cosine ? RCP1_COS : RCP1_SIN;
        b_prod  = P1_W'(n_b.hi) * P1_W'(b_rcp);
        n_b.qh  = b_prod[RCP1_SH +: HI_W];
    end

    // stage c: remainder of the upper chunk
    always_comb begin
        n_c.ctl = r_b.ctl;
        n_c.qh  = r_b.qh;
        n_c.lo  = r_b.lo;
        c_div   = r_b.ctl.cosine ? DIV_COS : DIV_SIN;
        c_qn    = QN_W'(r_b.qh) * QN_W'(c_div);
        c_rem   = r_b.hi - c_qn[HI_W-1:0];
        n_c.rh  = c_rem[DIV_W-1:0];
    end

    // stage d: remainder carried into the lower chunk, quotient reassembled
    always_comb begin
        n_d.ctl  = r_c.ctl;
        d_num    = {r_c.rh, r_c.lo};
        d_rcp    = r_c.ctl.cosine ? RCP2_COS : RCP2_SIN;
        d_prod   = P2_W'(d_num) * P2_W'(d_rcp);
        n_d.term = {r_c.qh[TERM_W-LO_W-1:0], d_prod[RCP2_SH +: LO_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.ctl.valid <= 1'b0;
            r_b.ctl.valid <= 1'b0;
            r_c.ctl.valid <= 1'b0;
            r_d.ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
        end
    end

    assign o_stage = r_d;

endmodule

// ===== rtl/sine_cosine_taylor_series_core.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_taylor_series_core
// pipelined fixed-point sine and cosine by truncated taylor series
// ----------------------------------------------------------------------------
// Takes one angle transaction per clock while input ready is high (signed
// q3.12 radians plus a sine or cosine select) and returns one q2.14 result
// transaction per angle, in order. Sine uses SINE_TERMS terms and cosine
// COSINE_TERMS terms; each term after the first costs two series steps, and
// every step is four register stages (multiply by |x|, then an exact divide
// by the step's constant done as two reciprocal multiplies). The pipeline
// holds S = 2*(max(SINE_TERMS, COSINE_TERMS)-1) steps, and throughput is one
// transaction per clock whenever the output side keeps taking results. The
// output register is backed by a one-entry skid buffer, so input ready is a
// plain register and the pipeline keeps moving while one result waits.
// Angles whose magnitude exceeds the angle limit register give a zero value
// with out_of_range set. The limit is written through the configuration
// channel, which is always ready; write it only while the core is empty.
// ----------------------------------------------------------------------------
module sine_cosine_taylor_series_core #(
    parameter int SINE_TERMS   = sct_pkg::SINE_TERMS_DEF,
    parameter int COSINE_TERMS = sct_pkg::COSINE_TERMS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sct_cfg_if.sink    i_cfg,
    sct_in_if.sink     i_in,
    sct_out_if.source  o_out
);

    localparam int ANGLE_W  = sct_pkg::ANGLE_W;
    localparam int LIMIT_W  = sct_pkg::LIMIT_W;
    localparam int VALUE_W  = sct_pkg::VALUE_W;
    localparam int MAG_W    = sct_pkg::MAG_W;
    localparam int TERM_W   = sct_pkg::TERM_W;
    localparam int SUM_W    = sct_pkg::SUM_W;
    localparam int ROUND_SH = sct_pkg::ROUND_SH;
    localparam int RND_W    = sct_pkg::RND_W;

    // number of series steps, set by the longer of the two series
    localparam int N_STEPS = sct_pkg::series_steps(SINE_TERMS, COSINE_TERMS);

    // the last term leaves the final step and is folded in here
    localparam sct_pkg::t_term_op OP_FIN_SIN = sct_pkg::term_op(N_STEPS, SINE_TERMS);
    localparam sct_pkg::t_term_op OP_FIN_COS = sct_pkg::term_op(N_STEPS, COSINE_TERMS);

    // magnitude and sign after the final sum
    typedef struct packed {
        logic              valid;
        logic              cosine;
        logic              neg_angle;
        logic              oor;
        logic              neg;
        logic [SUM_W-1:0]  smag;
    } t_abs;

    // finished result
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               oor;
    } t_res;

    logic [LIMIT_W-1:0] r_limit;

    sct_pkg::t_stage r_s0, n_s0;
    sct_pkg::t_stage w_stage [0:N_STEPS];
    sct_pkg::t_ctl   r_acc, n_acc;
    t_abs            r_abs, n_abs;
    t_res            r_fin, n_fin;
    t_res            r_out;
    t_res            r_skid;

    logic                    w_en;
    logic                    w_out_free;
    logic [ANGLE_W-1:0]      s0_abs;
    logic                    s0_oor;
    sct_pkg::t_term_op       acc_op;
    logic signed [SUM_W-1:0] acc_term;
    logic [SUM_W-1:0]        fin_sum;
    logic [RND_W-1:0]        fin_rnd;
    logic                    fin_neg;
    logic [VALUE_W-1:0]      fin_mag;

    // ------------------------------------------------------------------
    // configuration: angle limit, written whenever the channel is valid
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= sct_pkg::LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // pipeline advance: everything moves unless the skid entry is taken
    // ------------------------------------------------------------------
    assign w_en       = !r_skid.valid;
    assign i_in.ready = w_en;

    // ------------------------------------------------------------------
    // entry stage: magnitude, range check and first term
    // ------------------------------------------------------------------
    always_comb begin
        // the most negative angle gives a magnitude above any limit
        s0_abs = i_in.angle[ANGLE_W-1] ? ANGLE_W'(~i_in.angle + 1'b1) : i_in.angle;
        s0_oor = s0_abs > ANGLE_W'(r_limit);

        n_s0.ctl.valid     = i_in.valid;
        n_s0.ctl.cosine    = i_in.func;
        n_s0.ctl.neg_angle = i_in.angle[ANGLE_W-1];
        n_s0.ctl.oor       = s0_oor;
        // out of range angles run through as zero, the result is forced later
        n_s0.ctl.mag       = s0_oor ? '0 : s0_abs[MAG_W-1:0];
        // cosine starts at one, sine at |x|, both in q28
        n_s0.term          = i_in.func ? sct_pkg::TERM_ONE
                                       : (TERM_W'(n_s0.ctl.mag) << sct_pkg::INIT_SH);
        n_s0.ctl.sum       = signed'(SUM_W'(n_s0.term));
    end

    assign w_stage[0] = r_s0;

    // ------------------------------------------------------------------
    // series steps, each four stages deep
    // ------------------------------------------------------------------
    for (genvar s = 0; s < N_STEPS; s++) begin : g_step
        sct_step #(
            .STEP         (s),
            .SINE_TERMS   (SINE_TERMS),
            .COSINE_TERMS (COSINE_TERMS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_stage[s]),
            .o_stage (w_stage[s+1])
        );
    end

    // ------------------------------------------------------------------
    // final accumulate
    // ------------------------------------------------------------------
    always_comb begin
        n_acc    = w_stage[N_STEPS].ctl;
        acc_op   = w_stage[N_STEPS].ctl.cosine ? OP_FIN_COS : OP_FIN_SIN;
        acc_term = signed'(SUM_W'(w_stage[N_STEPS].term));
        unique case (acc_op)
            sct_pkg::OP_ADD: n_acc.sum = w_stage[N_STEPS].ctl.sum + acc_term;
            sct_pkg::OP_SUB: n_acc.sum = w_stage[N_STEPS].ctl.sum - acc_term;
            default:         n_acc.sum = w_stage[N_STEPS].ctl.sum;
        endcase
    end

    // ------------------------------------------------------------------
    // sign and magnitude of the q28 sum
    // ------------------------------------------------------------------
    always_comb begin
        n_abs.valid     = r_acc.valid;
        n_abs.cosine    = r_acc.cosine;
        n_abs.neg_angle = r_acc.neg_angle;
        n_abs.oor       = r_acc.oor;
        n_abs.neg       = r_acc.sum[SUM_W-1];
        n_abs.smag      = n_abs.neg ? SUM_W'(-r_acc.sum) : SUM_W'(r_acc.sum);
    end

    // ------------------------------------------------------------------
    // round half away from zero to q14, odd symmetry for sine, saturate
    // ------------------------------------------------------------------
    always_comb begin
        fin_sum = r_abs.smag + sct_pkg::ROUND_HALF;
        fin_rnd = fin_sum[SUM_W-1:ROUND_SH];
        fin_neg = r_abs.neg ^ (!r_abs.cosine && r_abs.neg_angle);

        if (fin_neg) begin
            fin_mag = (fin_rnd > RND_W'(sct_pkg::NEG_LIMIT)) ? sct_pkg::NEG_LIMIT
                                                             : fin_rnd[VALUE_W-1:0];
        end else begin
            fin_mag = (fin_rnd > RND_W'(sct_pkg::POS_LIMIT)) ? sct_pkg::POS_LIMIT
                                                             : fin_rnd[VALUE_W-1:0];
        end

        n_fin.valid = r_abs.valid;
        n_fin.oor   = r_abs.oor;
        // a zero magnitude stays zero when negated
        if (r_abs.oor) begin
            n_fin.value = '0;
        end else if (fin_neg) begin
            n_fin.value = ~fin_mag + 1'b1;
        end else begin
            n_fin.value = fin_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.ctl.valid <= 1'b0;
            r_acc.valid    <= 1'b0;
            r_abs.valid    <= 1'b0;
            r_fin.valid    <= 1'b0;
        end else if (w_en) begin
            r_s0  <= n_s0;
            r_acc <= n_acc;
            r_abs <= n_abs;
            r_fin <= n_fin;
        end
    end

    // ------------------------------------------------------------------
    // output register with one skid entry behind it
    // ------------------------------------------------------------------
    assign w_out_free = !r_out.valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (w_out_free) begin
            // a parked result goes first, the pipeline is frozen meanwhile
            if (r_skid.valid) begin
                r_out        <= r_skid;
                r_skid.valid <= 1'b0;
            end else begin
                r_out <= r_fin;
            end
        end else if (w_en && r_fin.valid) begin
            // output held: park the result leaving the pipeline
            r_skid <= r_fin;
        end
    end

    assign o_out.valid        = r_out.valid;
    assign o_out.value        = r_out.value;
    assign o_out.out_of_range = r_out.oor;

endmodule

// ===== dv/sine_cosine_taylor_series_core_tb.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_taylor_series_core_tb
// self-checking bench for the pipelined taylor series sine/cosine core
// ----------------------------------------------------------------------------
// Angle transactions go in through the angle channel. Every accepted angle
// gets an expected result, from a bit-exact fixed-point predictor or from its
// typed table row, and that result is queued. Each result transaction that
// comes out is checked field by field against the oldest queued result. A
// short table of directed angles comes first. The table covers zero, the
// range edges, both functions and saturation under a limit of zero, the reset
// limit and the full limit. A random part follows, split into phases, and each
// phase writes a new angle limit while the core is empty. Both channels stall
// in random bursts, except in one mid-run stretch and in the final phase.
// ----------------------------------------------------------------------------
module sine_cosine_taylor_series_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_W = sct_pkg::ANGLE_W;
    localparam int LIMIT_W = sct_pkg::LIMIT_W;
    localparam int VALUE_W = sct_pkg::VALUE_W;

    // function select codes
    localparam logic FUNC_SINE   = 1'b0;
    localparam logic FUNC_COSINE = 1'b1;

    // angle to result latency, used only for the final settle time
    localparam int PIPE_LATENCY =
        4 * sct_pkg::series_steps(sct_pkg::SINE_TERMS_DEF, sct_pkg::COSINE_TERMS_DEF) + 4;

    localparam int NUM_ROWS   = 24;
    localparam int NUM_PHASES = 6;

    // one result transaction as seen on the output channel
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      out_of_range;
    } t_sc_result;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct {
        int                 limit;
        logic               func;
        int                 angle;
        bit                 typed;
        logic [VALUE_W-1:0] value;
        logic               oor;
    } t_angle_row;

    logic i_clk;
    logic i_rst_n;

    sct_cfg_if limit_ch ();
    sct_in_if  angle_ch ();
    sct_out_if result_ch ();

    sine_cosine_taylor_series_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (limit_ch),
        .i_in    (angle_ch),
        .o_out   (result_ch)
    );

    // results still owed by the core, oldest first
    t_sc_result         expected_results [$];
    logic [LIMIT_W-1:0] angle_limit;
    t_angle_row         directed_rows [NUM_ROWS];

    int fail_count;
    int n_angles;
    int n_oor;
    int n_saturated;
    int n_limit_writes;
    bit tx_stalls;
    bit rx_stalls;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #2ms;
        $display("timeout at %0t", $time);
        $display("sine_cosine_taylor_series_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor: series evaluated on the angle magnitude in q28, each term
    // built from the last by two multiply-by-|x| and divide-by-n steps
    // ------------------------------------------------------------------------
    function automatic t_sc_result series_value(input logic func,
                                                input logic signed [ANGLE_W-1:0] angle,
                                                input logic [LIMIT_W-1:0] limit);
        t_sc_result         res;
        logic [16:0]        mag;
        logic [63:0]        term;
        logic [63:0]        n;
        logic [63:0]        rmag;
        logic signed [63:0] acc;
        logic               neg;
        int                 nterms;
        int                 k;

        res.value        = '0;
        res.out_of_range = 1'b0;
        // -32768 gives a magnitude of 32768, always beyond any 15-bit limit
        mag = angle[ANGLE_W-1] ? (17'h10000 - {1'b0, angle}) : {1'b0, angle};
        if (mag > {2'b00, limit}) begin
            res.out_of_range = 1'b1;
            return res;
        end

        nterms = (func == FUNC_COSINE) ? sct_pkg::COSINE_TERMS_DEF : sct_pkg::SINE_TERMS_DEF;
        term   = (func == FUNC_COSINE) ? (64'd1 << sct_pkg::ONE_SH)
                                       : (64'(mag) << sct_pkg::INIT_SH);
        n      = (func == FUNC_COSINE) ? 64'd0 : 64'd1;
        acc    = signed'(term);
        for (k = 1; k < nterms; k++) begin
            term = ((term * 64'(mag)) >> sct_pkg::FRAC_SH) / (n + 64'd1);
            term = ((term * 64'(mag)) >> sct_pkg::FRAC_SH) / (n + 64'd2);
            n    = n + 64'd2;
            if (k % 2 == 1) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end

        // round the magnitude to q14, half away from zero
        neg  = (acc < 0);
        rmag = neg ? 64'(-acc) : 64'(acc);
        rmag = (rmag + 64'd8192) >> sct_pkg::ROUND_SH;
        // sine is odd, so it follows the sign of the angle
        if (func == FUNC_SINE && angle[ANGLE_W-1]) begin
            neg = !neg;
        end
        if (neg) begin
            res.value = (rmag > 64'd32768) ? sct_pkg::NEG_LIMIT : VALUE_W'(-rmag);
        end else begin
            res.value = (rmag > 64'd32767) ? sct_pkg::POS_LIMIT : VALUE_W'(rmag);
        end
        return res;
    endfunction

    // random angle, mostly inside the current limit, some near its edge
    function automatic logic signed [ANGLE_W-1:0] pick_angle(input int limit);
        int m;
        int sel;

        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
            m = $urandom_range(0, limit);
        end else if (sel <= 7) begin
            return ANGLE_W'($urandom);
        end else if (sel == 8) begin
            m = limit + $urandom_range(0, 3) - 1;
            if (m < 0) begin
                m = 0;
            end
        end else begin
            case ($urandom_range(0, 2))
                0:       return ANGLE_W'(-32768);
                1:       return ANGLE_W'(32767);
                default: return '0;
            endcase
        end
        return $urandom_range(0, 1) ? ANGLE_W'(-m) : ANGLE_W'(m);
    endfunction

    // ------------------------------------------------------------------------
    // angle channel driver
    // ------------------------------------------------------------------------
    task automatic send_angle(input logic func, input logic signed [ANGLE_W-1:0] angle,
                              input bit typed, input t_sc_result typed_res);
        t_sc_result res;

        angle_ch.valid <= 1'b1;
        angle_ch.func  <= func;
        angle_ch.angle <= angle;
        do @(posedge i_clk); while (!angle_ch.ready);
        // accepted at this edge, under the limit currently held
        res = typed ? typed_res : series_value(func, angle, angle_limit);
        expected_results.push_back(res);
        n_angles++;
        if (res.out_of_range) begin
            n_oor++;
        end else if (res.value == sct_pkg::POS_LIMIT || res.value == sct_pkg::NEG_LIMIT) begin
            n_saturated++;
        end
    endtask

    // random gap on the sender side, with junk on the payload
    task automatic sender_gap();
        if (tx_stalls && $urandom_range(0, 3) == 0) begin
            angle_ch.valid <= 1'b0;
            angle_ch.func  <= 1'($urandom);
            angle_ch.angle <= ANGLE_W'($urandom);
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // hold the sender until the core has handed back everything
    task automatic drain_results();
        angle_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // limit register write, only ever issued with the core empty
    task automatic write_limit(input int limit);
        drain_results();
        limit_ch.valid <= 1'b1;
        limit_ch.data  <= LIMIT_W'(limit);
        do @(posedge i_clk); while (!limit_ch.ready);
        angle_limit = LIMIT_W'(limit);
        n_limit_writes++;
        limit_ch.valid <= 1'b0;
        limit_ch.data  <= LIMIT_W'($urandom);
    endtask

    // ------------------------------------------------------------------------
    // result channel: ready toggles in random stall bursts
    // ------------------------------------------------------------------------
    initial begin
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_stalls && $urandom_range(0, 2) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_sc_result want;

        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result value %0d out_of_range %0b", $time,
                         result_ch.value, result_ch.out_of_range);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (result_ch.value !== want.value) begin
                    $display("%0t: value mismatch, expected %0d actual %0d", $time,
                             want.value, result_ch.value);
                    fail_count++;
                end
                if (result_ch.out_of_range !== want.out_of_range) begin
                    $display("%0t: out_of_range mismatch, expected %0b actual %0b",
                             $time, want.out_of_range, result_ch.out_of_range);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int         phase_limit [NUM_PHASES];
        int         phase_items [NUM_PHASES];
        t_sc_result typed_res;
        int         p;
        int         i;

        i_rst_n        <= 1'b0;
        angle_ch.valid <= 1'b0;
        angle_ch.func  <= FUNC_SINE;
        angle_ch.angle <= '0;
        limit_ch.valid <= 1'b0;
        limit_ch.data  <= '0;
        angle_limit    = sct_pkg::LIMIT_RESET;
        fail_count     = 0;
        n_angles       = 0;
        n_oor          = 0;
        n_saturated    = 0;
        n_limit_writes = 0;
        tx_stalls      = 1'b1;
        rx_stalls      = 1'b1;

        // limit, func, angle, typed, value, out_of_range
        directed_rows = '{
            // reset limit: zero, both functions, the range edges
            '{12867, FUNC_SINE,        0, 1, 16'sd0,             1'b0},
            '{12867, FUNC_COSINE,      0, 1, 16'sd16384,         1'b0},
            '{12867, FUNC_SINE,    32767, 1, 16'sd0,             1'b1},
            '{12867, FUNC_COSINE, -32768, 1, 16'sd0,             1'b1},
            '{12867, FUNC_SINE,    12867, 0, 16'sd0,             1'b0},
            '{12867, FUNC_COSINE,  12867, 0, 16'sd0,             1'b0},
            '{12867, FUNC_SINE,   -12867, 0, 16'sd0,             1'b0},
            '{12867, FUNC_COSINE, -12867, 0, 16'sd0,             1'b0},
            '{12867, FUNC_SINE,    12868, 1, 16'sd0,             1'b1},
            '{12867, FUNC_COSINE, -12868, 1, 16'sd0,             1'b1},
            '{12867, FUNC_SINE,        1, 0, 16'sd0,             1'b0},
            '{12867, FUNC_SINE,       -1, 0, 16'sd0,             1'b0},
            '{12867, FUNC_COSINE,   6434, 0, 16'sd0,             1'b0},
            '{12867, FUNC_SINE,    -6434, 0, 16'sd0,             1'b0},
            // limit of zero: only a zero angle gets through
            '{0,     FUNC_SINE,        0, 1, 16'sd0,             1'b0},
            '{0,     FUNC_COSINE,      0, 1, 16'sd16384,         1'b0},
            '{0,     FUNC_SINE,        1, 1, 16'sd0,             1'b1},
            '{0,     FUNC_COSINE,     -1, 1, 16'sd0,             1'b1},
            // full limit: series leaves q2.14 near 8 rad and saturates
            '{32767, FUNC_SINE,    32767, 1, sct_pkg::POS_LIMIT, 1'b0},
            '{32767, FUNC_SINE,   -32767, 1, sct_pkg::NEG_LIMIT, 1'b0},
            '{32767, FUNC_COSINE,  32767, 1, sct_pkg::POS_LIMIT, 1'b0},
            '{32767, FUNC_COSINE, -32767, 1, sct_pkg::POS_LIMIT, 1'b0},
            '{32767, FUNC_SINE,   -32768, 1, 16'sd0,             1'b1},
            '{32767, FUNC_COSINE,  20000, 0, 16'sd0,             1'b0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, limit written whenever a row asks for another one
        for (i = 0; i < NUM_ROWS; i++) begin
            if (LIMIT_W'(directed_rows[i].limit) != angle_limit) begin
                write_limit(directed_rows[i].limit);
            end
            typed_res.value        = directed_rows[i].value;
            typed_res.out_of_range = directed_rows[i].oor;
            send_angle(directed_rows[i].func, ANGLE_W'(directed_rows[i].angle),
                       directed_rows[i].typed, typed_res);
            sender_gap();
        end

        // random phases, each under its own limit, extremes among them
        phase_limit = '{12867, 32767, 0, 1, 12867, 12867};
        phase_limit[3] = $urandom_range(1, 32766);
        phase_limit[4] = $urandom_range(1, 32766);
        phase_items = '{120, 120, 40, 120, 120, 110};
        typed_res   = '0;
        for (p = 0; p < NUM_PHASES; p++) begin
            write_limit(phase_limit[p]);
            // a stretch with no stalls mid-run, and none at all at the end
            tx_stalls = (p != 3 && p != NUM_PHASES - 1);
            rx_stalls = (p != 3 && p != NUM_PHASES - 1);
            for (i = 0; i < phase_items[p]; i++) begin
                if (p == 1 && i == 60) begin
                    drain_results();
                end
                send_angle(1'($urandom), pick_angle(int'(angle_limit)), 1'b0, typed_res);
                sender_gap();
            end
        end

        drain_results();
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            fail_count++;
        end
        $display("checked %0d angles over %0d limit settings: %0d out of range, %0d saturated",
                 n_angles, n_limit_writes, n_oor, n_saturated);
        if (fail_count == 0) begin
            $display("sine_cosine_taylor_series_core verification clean");
        end else begin
            $display("sine_cosine_taylor_series_core verification failed");
        end
        $finish;
    end

endmodule
